// ===== sv/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and the arctangent table for the wheel odometry
// block.
// ----------------------------------------------------------------------------
package odo_pkg;

  // Field widths
  localparam int INC_W      = 24;
  localparam int POS_W      = 32;
  localparam int ANGLE_W    = 32;
  localparam int DGAIN_W    = 24;
  localparam int TGAIN_W    = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int ATAN_IDX_W = 5;

  // CORDIC iteration count: default and upper bound
  localparam int ANGLE_ITERATIONS_DEFAULT = 16;
  localparam int ANGLE_ITERATIONS_MAX     = 32;

  // Register reset values
  localparam logic [DGAIN_W-1:0] DIST_GAIN_RESET = 24'd168611;
  localparam logic [TGAIN_W-1:0] TURN_GAIN_RESET = 32'd241047395;

  // CORDIC gain compensation, 0.6072529 in Q0.28
  localparam logic [27:0] CORDIC_GAIN = 28'd163008219;

  // Register indexes (paddr word index)
  localparam logic REG_DISTANCE_GAIN = 1'b0;
  localparam logic REG_TURN_GAIN     = 1'b1;

  typedef struct packed {
    logic signed [INC_W-1:0] left_increment;
    logic signed [INC_W-1:0] right_increment;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANGLE_W-1:0]      heading_angle;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                  accept;   // form both gain products
    logic                  scale;    // round products, form mid-step heading
    logic                  mul;      // gain-compensate the distance
    logic                  prep;     // fold quadrant, load rotation registers
    logic                  step;     // one CORDIC micro-rotation
    logic                  commit;   // add displacement to pose
    logic [ATAN_IDX_W-1:0] iter_idx;
  } cmd_t;

  function automatic logic [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/odo_regs.sv =====
// ----------------------------------------------------------------------------
// odo_regs
// APB-style configuration registers: distance gain and turn gain.
// ----------------------------------------------------------------------------
module odo_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [odo_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [odo_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [odo_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output logic [odo_pkg::DGAIN_W-1:0]     distance_gain,
  output logic [odo_pkg::TGAIN_W-1:0]     turn_gain
);
  import odo_pkg::*;

  logic [DGAIN_W-1:0] dist_gain_r;
  logic [TGAIN_W-1:0] turn_gain_r;
  logic               wr_en;
  logic               reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_gain_r <= DIST_GAIN_RESET;
      turn_gain_r <= TURN_GAIN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DISTANCE_GAIN: dist_gain_r <= cfg_pwdata[DGAIN_W-1:0];
        REG_TURN_GAIN:     turn_gain_r <= cfg_pwdata[TGAIN_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DISTANCE_GAIN: cfg_prdata = APB_DATA_W'(dist_gain_r);
      REG_TURN_GAIN:     cfg_prdata = APB_DATA_W'(turn_gain_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign distance_gain = dist_gain_r;
  assign turn_gain     = turn_gain_r;

endmodule

// ===== sv/odo_ctrl.sv =====
// ----------------------------------------------------------------------------
// odo_ctrl
// Step sequencer: walks one item through products, scaling, the CORDIC
// loop and the pose commit, and owns both handshakes.
// ----------------------------------------------------------------------------
module odo_ctrl #(
  parameter int ANGLE_ITERATIONS = odo_pkg::ANGLE_ITERATIONS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output odo_pkg::cmd_t  cmd
);
  import odo_pkg::*;

  localparam int IW = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_ITER  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          iter_last;
  logic          commit;

  assign iter_last = (iter_r == IW'(ANGLE_ITERATIONS - 1));
  // The pose registers are the output register: update only once the
  // previous result has left.
  assign commit    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_PREP;
      S_PREP: begin
        state_nxt = S_ITER;
        iter_nxt  = '0;
      end
      S_ITER: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_last) state_nxt = S_DONE;
      end
      S_DONE:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd.accept   = in_valid && (state_r == S_IDLE);
    cmd.scale    = (state_r == S_SCALE);
    cmd.mul      = (state_r == S_MUL);
    cmd.prep     = (state_r == S_PREP);
    cmd.step     = (state_r == S_ITER);
    cmd.commit   = commit;
    cmd.iter_idx = ATAN_IDX_W'(iter_r);
  end

endmodule

// ===== sv/odo_datapath.sv =====
// ----------------------------------------------------------------------------
// odo_datapath
// Gain products, rounding, quadrant fold, shared CORDIC rotator and the
// pose accumulators.
// ----------------------------------------------------------------------------
module odo_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  odo_pkg::cmd_t                cmd,
  input  odo_pkg::in_t                 in_data,
  input  logic [odo_pkg::DGAIN_W-1:0]  distance_gain,
  input  logic [odo_pkg::TGAIN_W-1:0]  turn_gain,
  output odo_pkg::out_t                out_data
);
  import odo_pkg::*;

  localparam int SUM_W  = INC_W + 1;
  localparam int PD_W   = DGAIN_W + 1 + SUM_W;   // distance product
  localparam int PT_W   = TGAIN_W + 1 + SUM_W;   // turn product
  localparam int D_W    = PD_W - 16;             // rounded distance
  localparam int GK_W   = 29;                    // signed gain constant
  localparam int XP_W   = D_W + GK_W;            // compensated product
  localparam int X0_W   = XP_W - 28;
  localparam int XW     = 40;                    // rotator x/y
  localparam int ZW     = ANGLE_W + 1;           // rotator residual angle

  logic signed [SUM_W-1:0] inc_sum, inc_diff;
  logic signed [PD_W-1:0]  prod_d_r;
  logic signed [PT_W-1:0]  prod_t_r;
  logic signed [PD_W-1:0]  d_round;
  logic signed [PT_W-1:0]  t_round_full, t_round_half;
  logic signed [D_W-1:0]   d_r;
  logic [ANGLE_W-1:0]      dth_r;
  logic [ANGLE_W-1:0]      mid_r;
  logic signed [XP_W-1:0]  xprod_r;
  logic signed [XW-1:0]    x0, x_r, y_r, xs, ys;
  logic signed [ZW-1:0]    z_r, atan_ext;
  logic                    fold;
  logic [ANGLE_W-1:0]      mid_fold;
  logic signed [XW-1:0]    x_rnd, y_rnd;
  logic [POS_W-1:0]        pose_x_r, pose_y_r;
  logic [ANGLE_W-1:0]      pose_heading_r;

  assign inc_sum  = {in_data.left_increment[INC_W-1], in_data.left_increment}
                  + {in_data.right_increment[INC_W-1], in_data.right_increment};
  assign inc_diff = {in_data.right_increment[INC_W-1], in_data.right_increment}
                  - {in_data.left_increment[INC_W-1], in_data.left_increment};

  // Round half up at bit 16 (distance, heading step) and bit 17 (half step)
  assign d_round      = prod_d_r + PD_W'(32'sd32768);
  assign t_round_full = prod_t_r + PT_W'(32'sd32768);
  assign t_round_half = prod_t_r + PT_W'(32'sd65536);

  // Mid headings in the left half-plane rotate by a half turn, x flips
  assign x0       = {{(XW-X0_W){xprod_r[XP_W-1]}}, xprod_r[XP_W-1:28]};
  assign fold     = mid_r[ANGLE_W-1] ^ mid_r[ANGLE_W-2];
  assign mid_fold = {mid_r[ANGLE_W-1] ^ fold, mid_r[ANGLE_W-2:0]};

  assign xs       = x_r >>> cmd.iter_idx;
  assign ys       = y_r >>> cmd.iter_idx;
  assign atan_ext = $signed({1'b0, atan_lut(cmd.iter_idx)});

  assign x_rnd = x_r + XW'(32'sd128);
  assign y_rnd = y_r + XW'(32'sd128);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod_d_r <= $signed({1'b0, distance_gain}) * inc_sum;
      prod_t_r <= $signed({1'b0, turn_gain}) * inc_diff;
    end
    if (cmd.scale) begin
      d_r   <= d_round[PD_W-1:16];
      dth_r <= t_round_full[ANGLE_W+15:16];
      mid_r <= pose_heading_r + t_round_half[ANGLE_W+16:17];
    end
    if (cmd.mul) begin
      xprod_r <= d_r * $signed({1'b0, CORDIC_GAIN});
    end
    if (cmd.prep) begin
      x_r <= fold ? -x0 : x0;
      y_r <= '0;
      z_r <= $signed({mid_fold[ANGLE_W-1], mid_fold});
    end else if (cmd.step) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_ext;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r       <= '0;
      pose_y_r       <= '0;
      pose_heading_r <= '0;
    end else if (cmd.commit) begin
      pose_x_r       <= pose_x_r + x_rnd[POS_W+7:8];
      pose_y_r       <= pose_y_r + y_rnd[POS_W+7:8];
      pose_heading_r <= pose_heading_r + dth_r;
    end
  end

  assign out_data.pos_x         = $signed(pose_x_r);
  assign out_data.pos_y         = $signed(pose_y_r);
  assign out_data.heading_angle = pose_heading_r;

endmodule

// ===== sv/diff_drive_encoder_odometry.sv =====
// ----------------------------------------------------------------------------
// diff_drive_encoder_odometry
// Differential-drive wheel odometry with midpoint heading rule.
// ----------------------------------------------------------------------------
// Each input item carries the left and right wheel angle increments (radians,
// Q8.16). The block forms the travelled distance as distance_gain times the
// increment sum and the heading change as turn_gain times the increment
// difference (a binary angle, 2^32 per turn), then advances x and y along the
// mid-step heading using an iterative CORDIC rotator, and returns the updated
// pose (x, y in Q16.16 meters, heading as a binary angle). Position and heading
// wrap; the pose clears on reset. The gain products are captured at the edge
// that accepts the item; after that the item goes through rounding, the
// gain-compensation multiply, the rotator load, ANGLE_ITERATIONS micro-rotations
// of the shared CORDIC stage, and the pose commit. out_valid rises with
// that commit. The pose registers double as the result register, so the next
// item is accepted in the cycle after the commit, even while that result still
// waits on out_ready; no new item is taken while one is in flight. A commit
// waits only if the previous result has not yet been taken. Write the gain
// registers only while idle.
// ----------------------------------------------------------------------------
module diff_drive_encoder_odometry #(
  parameter int ANGLE_ITERATIONS = odo_pkg::ANGLE_ITERATIONS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  odo_pkg::in_t                    in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output odo_pkg::out_t                   out_data,
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [odo_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [odo_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [odo_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import odo_pkg::*;

  cmd_t               cmd;
  logic [DGAIN_W-1:0] distance_gain;
  logic [TGAIN_W-1:0] turn_gain;

  // Gain registers
  odo_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .distance_gain (distance_gain),
    .turn_gain     (turn_gain)
  );

  // Sequencer: handshakes, step order and CORDIC iteration count
  odo_ctrl #(
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic and pose state; the item is sampled straight off in_data at
  // acceptance into the product registers
  odo_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_data       (in_data),
    .distance_gain (distance_gain),
    .turn_gain     (turn_gain),
    .out_data      (out_data)
  );

endmodule

// ===== verif/tb_diff_drive_encoder_odometry.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_diff_drive_encoder_odometry
// Self-checking bench for the differential-drive wheel odometry block.
// ----------------------------------------------------------------------------
// Drives wheel increment items through the valid/ready input channel and
// compares every pose item on the result channel against a cycle-free
// predictor of the pose update: gain products, rounding, midpoint heading,
// quadrant fold and CORDIC rotation. Gains are written through the APB port
// only while the block is idle. Runs a short directed set, then several random
// phases under different gain settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_diff_drive_encoder_odometry;
  import odo_pkg::*;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ROTATE_STEPS     = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;
  // Acceptance to result, plus slack for the drain waits.
  localparam int LATENCY          = ANGLE_ITERATIONS + 5;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int IDLE_PERCENT     = 24;
  localparam int PRINT_LIMIT      = 40;
  // 0.6072529 in Q0.28: undo the CORDIC magnitude growth up front.
  localparam longint GAIN_COMP    = 64'd163008219;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr   = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata  = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Predictor copies of the gain registers and the pose.
  logic [23:0] dist_scale;
  logic [31:0] turn_scale;
  logic [31:0] track_x;
  logic [31:0] track_y;
  logic [31:0] track_heading;

  out_t pose_expected[$];
  int   mismatch_count = 0;
  int   pose_count = 0;
  int   cycle_count = 0;
  bit   idling_on = 1'b1;

  // Arctangent of 2^-i as a binary angle, 2^32 per turn.
  longint atan_step [0:31] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000
  };

  // Corner values of a 24-bit signed increment.
  logic [23:0] corner_values [0:4] = '{
    24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000001
  };

  diff_drive_encoder_odometry #(
    .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Hard stop: no correct run comes near this.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Round to nearest, ties up: floor((v + 2^(s-1)) / 2^s).
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Apply one pair of wheel increments to the tracked pose and return the
  // pose the block must report for it.
  function automatic out_t advance_pose(input in_t step);
    longint      left_inc, right_inc;
    longint      dist_prod, turn_prod, travel;
    longint      x, y, z, xs, ys;
    logic [31:0] dth, half, mid, fold;
    out_t        pose;
    left_inc  = $signed(step.left_increment);
    right_inc = $signed(step.right_increment);
    dist_prod = longint'(dist_scale) * (left_inc + right_inc);
    turn_prod = longint'(turn_scale) * (right_inc - left_inc);
    travel = round_shift(dist_prod, 16);
    dth  = 32'(round_shift(turn_prod, 16));
    half = 32'(round_shift(turn_prod, 17));
    // Midpoint heading sets the direction of travel.
    mid  = track_heading + half;
    x    = (travel * GAIN_COMP) >>> 28;
    y    = 0;
    // Fold the back half-plane onto the front one by flipping the vector.
    fold = mid + 32'h40000000;
    if (fold[31]) begin
      x   = -x;
      mid = mid + 32'h80000000;
    end
    z = longint'($signed(mid));
    for (int i = 0; i < ROTATE_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[i];
      end
    end
    track_x       = track_x + 32'(round_shift(x, 8));
    track_y       = track_y + 32'(round_shift(y, 8));
    track_heading = track_heading + dth;
    pose.pos_x         = track_x;
    pose.pos_y         = track_y;
    pose.heading_angle = track_heading;
    return pose;
  endfunction

  function automatic in_t random_wheel_step();
    in_t step;
    step.left_increment  = 24'($urandom);
    step.right_increment = 24'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // Realistic encoder deltas: a few hundredths of a radian.
        step.left_increment  = 24'($urandom_range(4000)) - 24'd2000;
        step.right_increment = 24'($urandom_range(4000)) - 24'd2000;
      end
      4: step.right_increment = step.left_increment;
      5: step.right_increment = -step.left_increment;
      6: begin
        step.left_increment  = corner_values[$urandom_range(4)];
        step.right_increment = corner_values[$urandom_range(4)];
      end
      default: ;
    endcase
    return step;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("MISMATCH pose %0d %s: got %h want %h", pose_count, field, got, want);
  endtask

  // Compare every accepted pose item against the oldest prediction.
  always @(posedge clk) begin : check_pose
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pose_expected.size() == 0) begin
        report_mismatch("unexpected item", out_data.heading_angle, 32'h0);
      end else begin
        want = pose_expected.pop_front();
        if (out_data.pos_x !== want.pos_x)
          report_mismatch("pos_x", out_data.pos_x, want.pos_x);
        if (out_data.pos_y !== want.pos_y)
          report_mismatch("pos_y", out_data.pos_y, want.pos_y);
        if (out_data.heading_angle !== want.heading_angle)
          report_mismatch("heading_angle", out_data.heading_angle, want.heading_angle);
      end
      pose_count++;
    end
  end

  // Receiver stalls at random unless idling is switched off.
  always @(negedge clk) begin
    out_ready <= !idling_on || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Offer one item; predict its pose at the edge where it is taken.
  task automatic drive_wheel_step(input in_t step);
    @(negedge clk);
    while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= step;
    do @(posedge clk); while (!in_ready);
    pose_expected.push_back(advance_pose(step));
  endtask

  task automatic drive_pair(input logic [23:0] left_inc, input logic [23:0] right_inc);
    in_t step;
    step.left_increment  = left_inc;
    step.right_increment = right_inc;
    drive_wheel_step(step);
  endtask

  // Drop valid, wait for every pose item, then let the pipeline go quiet.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pose_expected.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_gain_register(input logic reg_idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == REG_DISTANCE_GAIN)
      dist_scale = value[23:0];
    else
      turn_scale = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_gains(input logic [31:0] dist_gain, input logic [31:0] turn_gain);
    write_gain_register(REG_DISTANCE_GAIN, dist_gain);
    write_gain_register(REG_TURN_GAIN, turn_gain);
  endtask

  task automatic drive_random(input int count);
    repeat (count) drive_wheel_step(random_wheel_step());
  endtask

  // Reset gains: still, straight runs both ways, spins, corner increments and
  // turns that walk the heading through every quadrant.
  task automatic test_straight_and_spin();
    drive_pair(24'h000000, 24'h000000);
    drive_pair(24'h000001, 24'h000001);
    drive_pair(24'hFFFFFF, 24'hFFFFFF);
    drive_pair(24'h7FFFFF, 24'h7FFFFF);
    drive_pair(24'h800000, 24'h800000);
    drive_pair(24'h800000, 24'h7FFFFF);
    drive_pair(24'h7FFFFF, 24'h800000);
    drive_pair(24'hF00000, 24'h100000);
    drive_pair(24'h010000, 24'h030000);
    drive_pair(24'h123456, 24'h654321);
    drive_pair(24'hC00000, 24'h400000);
    drive_pair(24'h0000FF, 24'h000F00);
    settle_block();
  endtask

  // Extreme gain settings: full scale on both, then both zero (pose frozen).
  task automatic test_gain_extremes();
    set_gains(32'h00FFFFFF, 32'hFFFFFFFF);
    drive_pair(24'h7FFFFF, 24'h7FFFFF);
    drive_pair(24'h800000, 24'h7FFFFF);
    drive_pair(24'h7FFFFF, 24'h7FFFFE);
    drive_pair(24'h800000, 24'h800000);
    settle_block();
    set_gains(32'h00000000, 32'h00000000);
    drive_pair(24'h7FFFFF, 24'h800000);
    drive_pair(24'h7FFFFF, 24'h7FFFFF);
    drive_pair(24'h5A5A5A, 24'hA5A5A5);
    settle_block();
  endtask

  task automatic test_cruise_random();
    set_gains(32'd168611, 32'd241047395);
    drive_random(400);
    settle_block();
  endtask

  task automatic test_random_gains();
    repeat (4) begin
      set_gains($urandom & 32'h00FFFFFF, $urandom);
      drive_random(100);
      settle_block();
    end
  endtask

  // Back-to-back items with the receiver always ready.
  task automatic test_no_idle_burst();
    idling_on = 1'b0;
    set_gains(32'd168611, $urandom);
    drive_random(300);
    settle_block();
    idling_on = 1'b1;
  endtask

  // Full-scale distance gain and near-maximum straight drive: each step moves
  // about 256 m.
  task automatic test_position_wrap();
    in_t step;
    set_gains(32'h00FFFFFF, 32'd241047395);
    repeat (200) begin
      if ($urandom_range(9) == 0) begin
        step = random_wheel_step();
      end else begin
        step.left_increment  = 24'h7FFFFF - 24'($urandom_range(4095));
        step.right_increment = 24'h7FFFFF - 24'($urandom_range(4095));
        if ($urandom_range(1)) begin
          step.left_increment  = ~step.left_increment;
          step.right_increment = ~step.right_increment;
        end
      end
      drive_wheel_step(step);
    end
    settle_block();
  endtask

  // Hold off after every item until its pose has come back.
  task automatic test_drain_between_items();
    set_gains($urandom & 32'h00FFFFFF, 32'hFFFFFFFF);
    repeat (50) begin
      drive_wheel_step(random_wheel_step());
      @(negedge clk);
      in_valid <= 1'b0;
      while (pose_expected.size() != 0) @(posedge clk);
    end
    settle_block();
  endtask

  task automatic test_closing_random();
    set_gains($urandom & 32'h00FFFFFF, $urandom & 32'h0FFFFFFF);
    drive_random(130);
    settle_block();
  endtask

  initial begin
    dist_scale    = 24'd168611;
    turn_scale    = 32'd241047395;
    track_x       = '0;
    track_y       = '0;
    track_heading = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_straight_and_spin();
    test_gain_extremes();
    test_cruise_random();
    test_random_gains();
    test_no_idle_burst();
    test_position_wrap();
    test_drain_between_items();
    test_closing_random();

    // Catch any stray item after the last expected pose.
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && pose_expected.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
sv/odo_pkg.sv
sv/odo_regs.sv
sv/odo_ctrl.sv
sv/odo_datapath.sv
sv/diff_drive_encoder_odometry.sv
verif/tb_diff_drive_encoder_odometry.sv
